FILE: hdl/bwrl_pkg.sv
// Shared types and constants for the boundary wrap/reflect/limit block.
`default_nettype none

package bwrl_pkg;

	localparam int VB      = 32;
	localparam int REG_W   = 32;
	localparam int ADDR_W  = 4;
	localparam int LATENCY = VB + 5;

	typedef enum logic [1:0] {
		KIND_OPEN    = 2'd0,
		KIND_LIMIT   = 2'd1,
		KIND_REFLECT = 2'd2,
		KIND_WRAP    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_LIMIT     = 2'd1,
		ST_ONE_WRAP  = 2'd2,
		ST_BAD_WIDTH = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_LOWER_KIND  = 2'd0,
		REG_UPPER_KIND  = 2'd1,
		REG_LOWER_BOUND = 2'd2,
		REG_UPPER_BOUND = 2'd3
	} reg_idx_t;

	typedef logic signed [VB-1:0] coord_t;

	typedef struct packed {
		kind_t         lower_kind;
		kind_t         upper_kind;
		coord_t        lower_bound;
		coord_t        upper_bound;
		logic [VB-1:0] width;
		logic [VB:0]   divisor;
		logic          width_ok;
	} cfg_t;

	typedef struct packed {
		logic          modp;
		logic          neg;
		logic [VB:0]   rem;
		logic [VB-1:0] dvd;
		coord_t        alt_res;
		status_t       alt_st;
	} cell_pkt_t;

endpackage

`default_nettype wire

FILE: hdl/bwrl_front.sv
// Front stages: offset magnitude, single reflection with saturation, limit checks.
`default_nettype none

module bwrl_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bwrl_pkg::cfg_t    cfg,
	input  wire logic              in_valid,
	input  wire bwrl_pkg::coord_t  value,
	output logic                   out_valid,
	output bwrl_pkg::cell_pkt_t    out_pkt
);
	import bwrl_pkg::*;

	localparam logic signed [VB+1:0] VMAX_E = {3'b000, {(VB-1){1'b1}}};
	localparam logic signed [VB+1:0] VMIN_E = {3'b111, {(VB-1){1'b0}}};
	localparam coord_t VMAX = {1'b0, {(VB-1){1'b1}}};
	localparam coord_t VMIN = {1'b1, {(VB-1){1'b0}}};

	logic                   v_s1, v_s2, v_s3;
	coord_t                 x_s1;
	logic                   modp_s2, neg_s2, chk_s2;
	logic [VB-1:0]          mag_s2;
	coord_t                 cand_s2;
	status_t                st_s2;
	logic                   modp_s3, neg_s3;
	logic [VB-1:0]          mag_s3;
	coord_t                 cand_s3;
	status_t                st_s3;

	logic                   one_wrap, both_wrap, both_refl, mod_mode, chk, neg, above;
	logic [VB-1:0]          mag;
	logic signed [VB+1:0]   lo_e, hi_e, x_e, refl_lo, refl_hi;
	coord_t                 cand;
	status_t                st;
	logic                   lim_hit;

	always_comb begin
		both_wrap = (cfg.lower_kind == KIND_WRAP) && (cfg.upper_kind == KIND_WRAP);
		one_wrap  = (cfg.lower_kind == KIND_WRAP) != (cfg.upper_kind == KIND_WRAP);
		both_refl = (cfg.lower_kind == KIND_REFLECT) && (cfg.upper_kind == KIND_REFLECT);
		mod_mode  = both_wrap || both_refl;
		chk       = !one_wrap && !mod_mode;
		neg       = x_s1 < cfg.lower_bound;
		above     = x_s1 > cfg.upper_bound;
		mag       = neg ? (cfg.lower_bound - x_s1) : (x_s1 - cfg.lower_bound);

		lo_e    = {{2{cfg.lower_bound[VB-1]}}, cfg.lower_bound};
		hi_e    = {{2{cfg.upper_bound[VB-1]}}, cfg.upper_bound};
		x_e     = {{2{x_s1[VB-1]}}, x_s1};
		// Mirror images 2*lo - x and 2*hi - x, exact before saturation.
		refl_lo = (lo_e <<< 1) - x_e;
		refl_hi = (hi_e <<< 1) - x_e;

		if (chk && (cfg.lower_kind == KIND_REFLECT) && neg) begin
			cand = (refl_lo > VMAX_E) ? VMAX : refl_lo[VB-1:0];
		end else if (chk && (cfg.upper_kind == KIND_REFLECT) && above) begin
			cand = (refl_hi < VMIN_E) ? VMIN : refl_hi[VB-1:0];
		end else begin
			cand = x_s1;
		end

		if (one_wrap) begin
			st = ST_ONE_WRAP;
		end else if (mod_mode && !cfg.width_ok) begin
			st = ST_BAD_WIDTH;
		end else begin
			st = ST_OK;
		end
	end

	always_comb begin
		lim_hit = ((cfg.lower_kind == KIND_LIMIT) && (cand_s2 < cfg.lower_bound)) ||
			((cfg.upper_kind == KIND_LIMIT) && (cand_s2 > cfg.upper_bound));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			x_s1 <= value;
		end
		modp_s2 <= mod_mode && cfg.width_ok;
		neg_s2  <= neg;
		chk_s2  <= chk;
		mag_s2  <= mag;
		cand_s2 <= cand;
		st_s2   <= st;
		modp_s3 <= modp_s2;
		neg_s3  <= neg_s2;
		mag_s3  <= mag_s2;
		cand_s3 <= cand_s2;
		st_s3   <= (chk_s2 && lim_hit) ? ST_LIMIT : st_s2;
	end

	always_comb begin
		out_valid       = v_s3;
		out_pkt.modp    = modp_s3;
		out_pkt.neg     = neg_s3;
		out_pkt.rem     = '0;
		out_pkt.dvd     = mag_s3;
		out_pkt.alt_res = cand_s3;
		out_pkt.alt_st  = st_s3;
	end

endmodule

`default_nettype wire

FILE: hdl/bwrl_cell.sv
// One remainder cell: brings in one dividend bit and does a compare and subtract.
`default_nettype none

module bwrl_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [bwrl_pkg::VB:0] divisor,
	input  wire logic                  in_valid,
	input  wire bwrl_pkg::cell_pkt_t   in_pkt,
	output logic                       out_valid,
	output bwrl_pkg::cell_pkt_t        out_pkt
);
	import bwrl_pkg::*;

	logic          valid_q;
	cell_pkt_t     pkt_q;
	cell_pkt_t     nxt;
	logic [VB+1:0] trial, dext, diff;

	always_comb begin
		nxt   = in_pkt;
		trial = {in_pkt.rem, in_pkt.dvd[VB-1]};
		dext  = {1'b0, divisor};
		diff  = trial - dext;
		// The remainder stays below the divisor, so it fits back into VB+1 bits.
		if (trial >= dext) begin
			nxt.rem = diff[VB:0];
		end else begin
			nxt.rem = trial[VB:0];
		end
		nxt.dvd = {in_pkt.dvd[VB-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		pkt_q <= nxt;
	end

	assign out_valid = valid_q;
	assign out_pkt   = pkt_q;

endmodule

`default_nettype wire

FILE: hdl/bwrl_back.sv
// Back stages: wrap correction or reflective fold, then offset from the lower bound.
`default_nettype none

module bwrl_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bwrl_pkg::cfg_t      cfg,
	input  wire logic                in_valid,
	input  wire bwrl_pkg::cell_pkt_t in_pkt,
	output logic                     done,
	output bwrl_pkg::coord_t         adjusted,
	output logic [1:0]               status
);
	import bwrl_pkg::*;

	logic          v_s1;
	logic [VB-1:0] t_s1;
	logic          modp_s1;
	coord_t        alt_res_s1;
	status_t       alt_st_s1;
	logic          done_q;
	coord_t        adjusted_q;
	status_t       status_q;

	logic [VB-1:0] t;
	logic [VB:0]   m;
	logic [VB:0]   fold;

	always_comb begin
		m    = in_pkt.rem;
		fold = cfg.divisor - m;
		if (cfg.lower_kind == KIND_WRAP) begin
			// Negative offsets map to the positive remainder.
			t = (in_pkt.neg && (m != '0)) ? (cfg.width - m[VB-1:0]) : m[VB-1:0];
		end else begin
			t = (m < {1'b0, cfg.width}) ? m[VB-1:0] : fold[VB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= in_valid;
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		t_s1       <= t;
		modp_s1    <= in_pkt.modp;
		alt_res_s1 <= in_pkt.alt_res;
		alt_st_s1  <= in_pkt.alt_st;
		adjusted_q <= modp_s1 ? (cfg.lower_bound + t_s1) : alt_res_s1;
		status_q   <= modp_s1 ? ST_OK : alt_st_s1;
	end

	assign done     = done_q;
	assign adjusted = adjusted_q;
	assign status   = status_q;

endmodule

`default_nettype wire

FILE: hdl/boundary_wrap_reflect_limit.sv
// Top level: configuration registers, front stages, remainder cell chain and back stages.
`default_nettype none

// Brings one signed Q16.16 coordinate into the configured domain per transfer. The block takes
// a new coordinate every clock cycle (busy never rises) and presents its result on adjusted and
// status with done high for exactly one cycle; results come out in the order the coordinates
// went in. The pipeline is the chain of 32 remainder cells, one per coordinate bit, that
// computes the wrap or reflection modulo, plus three front stages and two back stages. The
// receiver cannot stall the output, so it must take every result in the cycle it appears.
// Configuration must be written by the user over the APB port only while no transfer is in
// flight; the block itself does not enforce this.
module boundary_wrap_reflect_limit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire bwrl_pkg::coord_t           value,
	output logic                            done,
	output bwrl_pkg::coord_t                adjusted,
	output logic [1:0]                      status,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [bwrl_pkg::ADDR_W-1:0] paddr,
	input  wire logic [bwrl_pkg::REG_W-1:0] pwdata,
	output logic [bwrl_pkg::REG_W-1:0]      prdata,
	output logic                            pready
);
	import bwrl_pkg::*;

	kind_t         lower_kind_q, upper_kind_q;
	coord_t        lower_bound_q, upper_bound_q;
	logic [VB-1:0] width_q;
	logic [VB:0]   divisor_q;
	logic          width_ok_q;
	logic [VB-1:0] width_d;
	reg_idx_t      idx;
	logic          wr_en;
	cfg_t          cfg;

	logic          chain_valid [VB+1];
	cell_pkt_t     chain_pkt [VB+1];

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_kind_q  <= KIND_OPEN;
			upper_kind_q  <= KIND_OPEN;
			lower_bound_q <= '0;
			upper_bound_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_LOWER_KIND:  lower_kind_q  <= kind_t'(pwdata[1:0]);
				REG_UPPER_KIND:  upper_kind_q  <= kind_t'(pwdata[1:0]);
				REG_LOWER_BOUND: lower_bound_q <= pwdata[VB-1:0];
				REG_UPPER_BOUND: upper_bound_q <= pwdata[VB-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_LOWER_KIND:  prdata = {{(REG_W-2){1'b0}}, lower_kind_q};
			REG_UPPER_KIND:  prdata = {{(REG_W-2){1'b0}}, upper_kind_q};
			REG_LOWER_BOUND: prdata = REG_W'(lower_bound_q);
			REG_UPPER_BOUND: prdata = REG_W'(upper_bound_q);
			default:         prdata = '0;
		endcase
	end

	// Domain width and the modulo divisor are registered from the bounds and follow them in the next cycle.
	assign width_d = upper_bound_q - lower_bound_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= '0;
			divisor_q  <= '0;
			width_ok_q <= 1'b0;
		end else begin
			width_q    <= width_d;
			width_ok_q <= upper_bound_q > lower_bound_q;
			if ((lower_kind_q == KIND_REFLECT) && (upper_kind_q == KIND_REFLECT)) begin
				divisor_q <= {width_d, 1'b0};
			end else begin
				divisor_q <= {1'b0, width_d};
			end
		end
	end

	always_comb begin
		cfg.lower_kind  = lower_kind_q;
		cfg.upper_kind  = upper_kind_q;
		cfg.lower_bound = lower_bound_q;
		cfg.upper_bound = upper_bound_q;
		cfg.width       = width_q;
		cfg.divisor     = divisor_q;
		cfg.width_ok    = width_ok_q;
	end

	bwrl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (start && !busy),
		.value     (value),
		.out_valid (chain_valid[0]),
		.out_pkt   (chain_pkt[0])
	);

	for (genvar k = 0; k < VB; k++) begin : g_cell
		bwrl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.divisor   (divisor_q),
			.in_valid  (chain_valid[k]),
			.in_pkt    (chain_pkt[k]),
			.out_valid (chain_valid[k+1]),
			.out_pkt   (chain_pkt[k+1])
		);
	end

	bwrl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (chain_valid[VB]),
		.in_pkt   (chain_pkt[VB]),
		.done     (done),
		.adjusted (adjusted),
		.status   (status)
	);

	// Every transfer produces its result once it has passed the whole pipeline.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("result missing after pipeline latency");

	a_one_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		done && ((lower_kind_q == KIND_WRAP) != (upper_kind_q == KIND_WRAP))
		|-> status == ST_ONE_WRAP)
		else $error("one-sided wrap not reported");

	a_wrap_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_OK) && (lower_kind_q == KIND_WRAP) &&
		(upper_kind_q == KIND_WRAP)
		|-> (adjusted >= lower_bound_q) && (adjusted < upper_bound_q))
		else $error("wrapped result outside domain");

	a_refl_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_OK) && (lower_kind_q == KIND_REFLECT) &&
		(upper_kind_q == KIND_REFLECT)
		|-> (adjusted >= lower_bound_q) && (adjusted <= upper_bound_q))
		else $error("folded result outside domain");

endmodule

`default_nettype wire

FILE: bench/tb_boundary_wrap_reflect_limit.sv
// Self-checking testbench for the boundary wrap/reflect/limit block.
`timescale 1ns / 1ps

module tb_boundary_wrap_reflect_limit;
	import bwrl_pkg::*;

	localparam int     CYCLE_LIMIT = 200_000;
	localparam int     ITEMS_PER_PHASE = 65;
	localparam int     RANDOM_PHASES = 30;
	localparam coord_t COORD_MAX = {1'b0, {(VB-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(VB-1){1'b0}}};
	localparam longint MAXV = COORD_MAX;
	localparam longint MINV = COORD_MIN;

	typedef struct {
		coord_t  adjusted;
		status_t status;
	} coord_result_t;

	// Holds a copy of the domain registers, computes the expected result and status of each
	// accepted coordinate and keeps them until the block returns them.
	class boundary_tracker;
		kind_t           lower_kind = KIND_OPEN;
		kind_t           upper_kind = KIND_OPEN;
		coord_t          lower_bound = '0;
		coord_t          upper_bound = '0;
		coord_result_t   expected_coords[$];
		int              failures = 0;

		function void set_register(reg_idx_t idx, logic [REG_W-1:0] data);
			case (idx)
				REG_LOWER_KIND:  lower_kind = kind_t'(data[1:0]);
				REG_UPPER_KIND:  upper_kind = kind_t'(data[1:0]);
				REG_LOWER_BOUND: lower_bound = coord_t'(data[VB-1:0]);
				REG_UPPER_BOUND: upper_bound = coord_t'(data[VB-1:0]);
				default: begin
				end
			endcase
		endfunction

		function void note_coordinate(coord_t v);
			longint        x, lo, hi, w, mag, t, res;
			logic          neg;
			status_t       st;
			coord_result_t entry;
			x = v;
			lo = lower_bound;
			hi = upper_bound;
			res = x;
			st = ST_OK;
			if ((lower_kind == KIND_WRAP) != (upper_kind == KIND_WRAP)) begin
				st = ST_ONE_WRAP;
			end else if (lower_kind == KIND_WRAP ||
					(lower_kind == KIND_REFLECT && upper_kind == KIND_REFLECT)) begin
				if (hi <= lo) begin
					st = ST_BAD_WIDTH;
				end else begin
					w = hi - lo;
					neg = x < lo;
					mag = neg ? lo - x : x - lo;
					if (lower_kind == KIND_WRAP) begin
						t = mag % w;
						if (neg && t != 0)
							t = w - t;
					end else begin
						// Fold over one full period of twice the width.
						t = mag % (2 * w);
						if (t >= w)
							t = 2 * w - t;
					end
					res = lo + t;
				end
			end else begin
				if (lower_kind == KIND_REFLECT && x < lo)
					res = (2 * lo - x > MAXV) ? MAXV : 2 * lo - x;
				else if (upper_kind == KIND_REFLECT && x > hi)
					res = (2 * hi - x < MINV) ? MINV : 2 * hi - x;
				if (lower_kind == KIND_LIMIT && res < lo)
					st = ST_LIMIT;
				else if (upper_kind == KIND_LIMIT && res > hi)
					st = ST_LIMIT;
			end
			entry = '{coord_t'(res), st};
			expected_coords = {expected_coords, entry};
		endfunction

		function void check_result(coord_t adj, status_t st);
			coord_result_t exp_res;
			if (expected_coords.size() == 0) begin
				$error("result with no coordinate pending: adjusted %0d, status %0d", adj, st);
				failures++;
			end else begin
				exp_res = expected_coords.pop_front();
				if (adj !== exp_res.adjusted) begin
					$error("adjusted mismatch: expected %0d, actual %0d", exp_res.adjusted, adj);
					failures++;
				end
				if (st !== exp_res.status) begin
					$error("status mismatch: expected %0d, actual %0d", exp_res.status, st);
					failures++;
				end
			end
		endfunction

		function int pending_count();
			return expected_coords.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	coord_t              value;
	logic                done;
	coord_t              adjusted;
	logic [1:0]          status;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [REG_W-1:0]    pwdata;
	logic [REG_W-1:0]    prdata;
	logic                pready;
	int                  cycle_count = 0;
	boundary_tracker     board;

	boundary_wrap_reflect_limit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.value   (value),
		.done    (done),
		.adjusted(adjusted),
		.status  (status),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("boundary_wrap_reflect_limit verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_result(adjusted, status_t'(status));
	end

	function automatic coord_t saturate(longint v);
		if (v > MAXV)
			return COORD_MAX;
		if (v < MINV)
			return COORD_MIN;
		return coord_t'(v);
	endfunction

	task automatic reg_write(reg_idx_t idx, logic [REG_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.set_register(idx, data);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Lowers start, lets every pending result drain, then rewrites all four registers.
	// The unused upper bits of the kind registers carry random junk.
	task automatic configure(kind_t lk, kind_t uk, coord_t lo, coord_t hi);
		@(negedge clk);
		start <= 1'b0;
		while (board.pending_count() != 0)
			@(posedge clk);
		reg_write(REG_LOWER_KIND, ($urandom & ~32'h3) | lk);
		reg_write(REG_UPPER_KIND, ($urandom & ~32'h3) | uk);
		reg_write(REG_LOWER_BOUND, lo);
		reg_write(REG_UPPER_BOUND, hi);
	endtask

	task automatic send_coordinate(coord_t v, int idle_pct);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		board.note_coordinate(v);
	endtask

	initial begin
		int     idle;
		coord_t lo, hi;
		longint span, cand;
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Both edges wrap: extremes, exact bounds and an exact period below the domain.
		configure(KIND_WRAP, KIND_WRAP, -65536, 196608);
		send_coordinate(COORD_MAX, 0);
		send_coordinate(COORD_MIN, 0);
		send_coordinate(0, 0);
		send_coordinate(-65536, 0);
		send_coordinate(196608, 0);
		send_coordinate(-327680, 0);
		send_coordinate(65535, 0);
		// Both edges reflect, including values that fold back from the far side.
		configure(KIND_REFLECT, KIND_REFLECT, 65536, 196608);
		send_coordinate(COORD_MIN, 0);
		send_coordinate(COORD_MAX, 0);
		send_coordinate(196609, 0);
		send_coordinate(-458747, 0);
		send_coordinate(327680, 0);
		// Non-positive width, for wrap and for reflect.
		configure(KIND_WRAP, KIND_WRAP, 1000, 1000);
		send_coordinate(5, 0);
		configure(KIND_REFLECT, KIND_REFLECT, 10, -10);
		send_coordinate(0, 0);
		// Wrap on one edge only.
		configure(KIND_WRAP, KIND_LIMIT, 0, 100);
		send_coordinate(500, 0);
		// Single reflection at the lower edge saturating high and so over the upper limit, then one inside.
		configure(KIND_REFLECT, KIND_LIMIT, 0, 100);
		send_coordinate(COORD_MIN, 0);
		send_coordinate(-50, 0);
		// Single reflection at the upper edge saturating low.
		configure(KIND_LIMIT, KIND_REFLECT, -5, -1);
		send_coordinate(COORD_MAX, 0);
		send_coordinate(3, 0);
		// Open edges ignore even inverted bounds.
		configure(KIND_OPEN, KIND_OPEN, COORD_MAX, COORD_MIN);
		send_coordinate(COORD_MIN, 0);
		send_coordinate(COORD_MAX, 0);
		configure(KIND_LIMIT, KIND_LIMIT, -100, 100);
		send_coordinate(-101, 0);
		send_coordinate(101, 0);
		send_coordinate(100, 0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			idle = (p < RANDOM_PHASES / 3) ? 23 : ((p < 2 * RANDOM_PHASES / 3) ? 78 : 0);
			case ($urandom_range(0, 5))
				0: begin
					lo = $urandom;
					hi = $urandom;
				end
				1: begin
					lo = $urandom;
					hi = saturate(longint'(lo) + int'($urandom_range(1, 1 << 20)));
				end
				2: begin
					lo = $urandom;
					hi = saturate(longint'(lo) + int'($urandom_range(1, 16)));
				end
				3: begin
					lo = COORD_MIN;
					hi = COORD_MAX;
				end
				4: begin
					lo = $urandom;
					hi = lo;
				end
				default: begin
					lo = saturate(MINV + int'($urandom_range(0, 1000)));
					hi = saturate(MAXV - int'($urandom_range(0, 1000)));
				end
			endcase
			// Paired wrap and paired reflect get extra weight; they need the modulo path.
			case ($urandom_range(0, 3))
				0: configure(KIND_WRAP, KIND_WRAP, lo, hi);
				1: configure(KIND_REFLECT, KIND_REFLECT, lo, hi);
				default: configure(kind_t'($urandom_range(0, 3)), kind_t'($urandom_range(0, 3)),
					lo, hi);
			endcase
			span = (longint'(hi) > longint'(lo)) ? longint'(hi) - longint'(lo) : 1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				case ($urandom_range(0, 9))
					0, 1, 2: cand = coord_t'($urandom);
					3, 4, 5, 6: cand = longint'(lo) + (int'($urandom_range(0, 7)) - 3) * span
						+ longint'($urandom) % span;
					7: begin
						case ($urandom_range(0, 7))
							0: cand = MINV;
							1: cand = MAXV;
							2: cand = lo;
							3: cand = hi;
							4: cand = longint'(lo) - 1;
							5: cand = longint'(hi) + 1;
							6: cand = longint'(lo) - span;
							default: cand = 0;
						endcase
					end
					default: cand = ($urandom_range(0, 1) ? longint'(lo) : longint'(hi))
						+ int'($urandom_range(0, 32)) - 16;
				endcase
				send_coordinate(saturate(cand), idle);
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (board.pending_count() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (board.failures == 0)
			$display("boundary_wrap_reflect_limit verification clean");
		else
			$display("boundary_wrap_reflect_limit verification failed");
		$finish;
	end

endmodule
